// ===== sv/dmr_pkg.sv =====
// dmr_pkg: shared widths, register indexes and sequencer states for the
// downmix linear resampler. No dependencies.
package dmr_pkg;

  localparam int SAMPLE_W = 16;  // pcm sample and mono sample width
  localparam int CC_W     = 4;   // channel_count register width
  localparam int STEP_W   = 20;  // phase_step register width
  localparam int CFG_W    = 20;  // config write data, widest register
  localparam int IDX_W    = 2;   // config register index width

  localparam int MAX_OUT   = 8;  // outputs per mono sample at most
  localparam int OUT_CNT_W = 3;

  localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] REG_RESAMPLE_ON   = 2'd1;
  localparam logic [IDX_W-1:0] REG_PHASE_STEP    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_MUL,
    S_ADD,
    S_OUT
  } dmr_state_t;

endpackage

// ===== sv/dmr_div.sv =====
// dmr_div: restoring divider, one quotient bit per cycle, signed dividend
// truncated toward zero by a small unsigned divisor. Depends on dmr_pkg.
module dmr_div import dmr_pkg::*; #(
  parameter int SUM_W = 19,
  parameter int CNT_W = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SUM_W-1:0]    dividend,
  input  logic        [CNT_W-1:0]    divisor,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] quotient
);

  localparam int CW = $clog2(SUM_W + 1);

  logic             busy;
  logic [CW-1:0]    count;
  logic             neg;
  logic [CNT_W-1:0] rem;
  logic [SUM_W-1:0] quo;

  logic [SUM_W-1:0] mag;
  logic [CNT_W:0]   rem_shift;
  logic [CNT_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    mag       = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    rem_shift = {rem, quo[SUM_W-1]};
    fits      = rem_shift >= {1'b0, divisor};
    rem_sub   = rem_shift - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CW'(SUM_W);
    end else if (busy) begin
      if (count != '0) begin
        count <= count - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= mag;
      rem <= '0;
    end else if (busy && count != '0) begin
      rem <= fits ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  // magnitude fits in 16 bits once divided, so the low SAMPLE_W bits are the answer
  assign done     = busy && (count == '0);
  assign quotient = neg ? -$signed(quo[SAMPLE_W-1:0]) : $signed(quo[SAMPLE_W-1:0]);

endmodule

// ===== sv/downmix_linear_resampler.sv =====
// downmix_linear_resampler: downmixes interleaved pcm to mono and resamples it
// by linear interpolation. Depends on dmr_pkg and dmr_div.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    sample_in, frame_end
//   out      source     out_valid / out_ready  sample_out, run_last
//   cfg      sink       cfg_write              cfg_index, cfg_data
//
// a sample that does not close a frame is only added to the channel sum
// a frame-closing sample runs the divider to the mono result, which is presented once
// in passthrough; when resampling, a check step follows and each output takes a
// multiply, an add and a present step, plus out_ready waits
// in_ready is low from a frame-closing transfer until its last result is taken
// synchronous reset restores config defaults and clears downmix state and phase; no clearing pass
module downmix_linear_resampler import dmr_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int FRAC_BITS    = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       frame_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       run_last,
  input  logic                       cfg_write,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_CHANNELS);
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int PH_W   = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam logic [PH_W-1:0] UNIT     = PH_W'(1) << FRAC_BITS;
  localparam logic [PH_W-1:0] MIN_STEP = UNIT >> 3;

  dmr_state_t state, state_next;

  logic [CC_W-1:0]   channel_count;
  logic              resample_on;
  logic [STEP_W-1:0] phase_step;

  logic signed [SUM_W-1:0]    channel_sum;
  logic        [CNT_W-1:0]    channel_seen;
  logic signed [SAMPLE_W-1:0] previous_mono;
  logic                       have_previous;
  logic        [PH_W-1:0]     phase;
  logic signed [SAMPLE_W-1:0] current_mono;
  logic        [OUT_CNT_W-1:0] out_count;
  logic signed [PROD_W-1:0]   product;

  logic [CNT_W-1:0]           eff_count;
  logic signed [SUM_W-1:0]    sum_new;
  logic [CNT_W-1:0]           seen_new;
  logic                       frame_done;
  logic                       in_fire;
  logic                       out_fire;
  logic [PH_W-1:0]            step_eff;
  logic [PH_W-1:0]            phase_adv;
  logic signed [DIFF_W-1:0]   diff;
  logic                       div_start;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_quotient;

  always_comb begin
    if (int'(channel_count) > MAX_CHANNELS) begin
      eff_count = CNT_W'(MAX_CHANNELS);
    end else if (channel_count == '0) begin
      eff_count = CNT_W'(1);
    end else begin
      eff_count = CNT_W'(channel_count);
    end
    sum_new    = channel_sum + SUM_W'(sample_in);
    seen_new   = channel_seen + 1'b1;
    frame_done = frame_end || (seen_new >= eff_count);
    in_fire    = in_valid && in_ready;
    out_fire   = out_valid && out_ready;
    step_eff   = (PH_W'(phase_step) < MIN_STEP) ? MIN_STEP : PH_W'(phase_step);
    phase_adv  = phase + step_eff;
    diff       = DIFF_W'(current_mono) - DIFF_W'(previous_mono);
  end

  dmr_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (eff_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && frame_done) state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (!resample_on)        state_next = S_OUT;
          else if (!have_previous) state_next = S_IDLE;
          else                     state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = (phase < UNIT) ? S_MUL : S_IDLE;
      S_MUL:   state_next = S_ADD;
      S_ADD:   state_next = S_OUT;
      S_OUT: begin
        if (out_fire) state_next = run_last ? S_IDLE : S_MUL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
    div_start = in_fire && frame_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      channel_count <= CC_W'(1);
      resample_on   <= 1'b0;
      phase_step    <= STEP_RESET;
      channel_sum   <= '0;
      channel_seen  <= '0;
      previous_mono <= '0;
      have_previous <= 1'b0;
      phase         <= '0;
      out_count     <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: channel_count <= cfg_data[CC_W-1:0];
          REG_RESAMPLE_ON:   resample_on   <= cfg_data[0];
          REG_PHASE_STEP:    phase_step    <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (frame_done) begin
              channel_sum  <= '0;
              channel_seen <= '0;
            end else begin
              channel_sum  <= sum_new;
              channel_seen <= seen_new;
            end
          end
        end
        S_DIV: begin
          out_count <= '0;
          if (div_done && (!resample_on || !have_previous)) begin
            previous_mono <= div_quotient;
            have_previous <= 1'b1;
          end
        end
        S_CHECK: begin
          // phase already at or past one unit: nothing to emit, just move on
          if (phase >= UNIT) begin
            phase         <= phase - UNIT;
            previous_mono <= current_mono;
          end
        end
        S_ADD: begin
          phase     <= phase_adv;
          out_count <= out_count + 1'b1;
        end
        S_OUT: begin
          if (out_fire && run_last && resample_on) begin
            if (phase >= UNIT) phase <= phase - UNIT;
            previous_mono <= current_mono;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_DIV: begin
        if (div_done) begin
          current_mono <= div_quotient;
          sample_out   <= div_quotient;
          run_last     <= 1'b1;
        end
      end
      S_MUL: product <= diff * $signed({1'b0, phase[FRAC_BITS-1:0]});
      S_ADD: begin
        // low bits of the shifted product equal floor(diff * frac / unit)
        sample_out <= previous_mono + $signed(product[FRAC_BITS +: SAMPLE_W]);
        run_last   <= (phase_adv >= UNIT) ||
                      (out_count == OUT_CNT_W'(MAX_OUT - 1));
      end
      default: ;
    endcase
  end

  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_fire && run_last) |=> in_ready)
    else $error("sequencer did not return to idle after the last transfer");

  a_mul_phase: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (phase < UNIT))
    else $error("interpolating with phase at or above one unit");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_pass_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !resample_on) |-> run_last)
    else $error("passthrough result without run_last");

endmodule

// ===== bench/downmix_linear_resampler_tb.sv =====
// downmix_linear_resampler_tb: self-checking bench for the downmix linear resampler.
// Uses dmr_pkg for widths and register indexes. A directed table runs first, then
// random frames under a series of register settings, scored against table values or a predictor.
module downmix_linear_resampler_tb import dmr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CHANNELS = 8;
  localparam int FRAC_BITS    = 16;
  localparam int UNIT         = 1 << FRAC_BITS;
  localparam int MIN_STEP     = UNIT >> 3;
  localparam int SETTLE_CYC   = 40;  // divider plus check, with margin
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 35;
  localparam int MAX_REPORTS  = 30;
  localparam logic [STEP_W-1:0] STEP_TOP = 20'hFFFFF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
  } mono_out_t;

  typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [CC_W-1:0]            cc;
    bit                         on;
    logic [STEP_W-1:0]          stp;
    logic signed [SAMPLE_W-1:0] smp;
    bit                         fe;
    bit                         typed;
    int                         exp_n;
    logic signed [SAMPLE_W-1:0] exp_smp;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       frame_end;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       run_last;
  logic                       cfg_write;
  logic [IDX_W-1:0]           cfg_index;
  logic [CFG_W-1:0]           cfg_data;

  // predictor copy of the registers and the downmix / phase state
  logic [CC_W-1:0]            cc_reg   = 4'd1;
  bit                         on_reg   = 1'b0;
  logic [STEP_W-1:0]          step_reg = STEP_RESET;
  logic signed [18:0]         mix_sum  = '0;
  logic [3:0]                 mix_seen = '0;
  logic signed [SAMPLE_W-1:0] prev_mono = '0;
  bit                         prev_valid = 1'b0;
  logic [20:0]                interp_phase = '0;

  mono_out_t run_buf [MAX_OUT];
  mono_out_t expected_mono [$];
  stim_row_t dir_tab [$];

  bit quiet = 1'b0;
  int n_fail = 0;
  int n_items = 0;
  int n_results = 0;
  int n_settings = 0;

  downmix_linear_resampler #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .frame_end (frame_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .run_last  (run_last),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int eff_count(input logic [CC_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_CHANNELS) return MAX_CHANNELS;
    return c;
  endfunction

  // accumulate one channel sample; on frame close, fill run_buf with the outputs
  function automatic int downmix_interp_step(input logic signed [SAMPLE_W-1:0] smp,
                                             input bit fe);
    int                         cnt;
    int                         n;
    logic signed [SAMPLE_W-1:0] mono;
    logic [STEP_W-1:0]          stp;
    longint                     d;
    longint                     p;
    cnt = eff_count(cc_reg);
    n = 0;
    mix_sum = mix_sum + smp;
    mix_seen = mix_seen + 4'd1;
    if (!fe && mix_seen < cnt) return 0;
    mono = SAMPLE_W'(int'(mix_sum) / cnt);
    mix_sum = '0;
    mix_seen = '0;
    if (!on_reg) begin
      prev_mono = mono;
      prev_valid = 1'b1;
      run_buf[0].smp = mono;
      run_buf[0].last = 1'b1;
      return 1;
    end
    if (!prev_valid) begin
      prev_mono = mono;
      prev_valid = 1'b1;
      return 0;
    end
    stp = (step_reg < MIN_STEP) ? STEP_W'(MIN_STEP) : step_reg;
    while (interp_phase < UNIT && n < MAX_OUT) begin
      d = longint'(mono) - longint'(prev_mono);
      p = d * longint'(interp_phase);
      // arithmetic shift floors toward minus infinity
      run_buf[n].smp = SAMPLE_W'(longint'(prev_mono) + (p >>> FRAC_BITS));
      run_buf[n].last = 1'b0;
      n++;
      interp_phase = interp_phase + stp;
    end
    if (interp_phase >= UNIT) interp_phase = interp_phase - 21'(UNIT);
    if (n > 0) run_buf[n-1].last = 1'b1;
    prev_mono = mono;
    return n;
  endfunction

  function automatic void tab_cfg(input logic [CC_W-1:0] cc, input bit on,
                                  input logic [STEP_W-1:0] stp);
    stim_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.cc = cc;
    r.on = on;
    r.stp = stp;
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  function automatic void tab_item(input logic signed [SAMPLE_W-1:0] smp, input bit fe,
                                   input bit typed, input int exp_n,
                                   input logic signed [SAMPLE_W-1:0] exp_smp);
    stim_row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.smp = smp;
    r.fe = fe;
    r.typed = typed;
    r.exp_n = exp_n;
    r.exp_smp = exp_smp;
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  task automatic send_pcm(input logic signed [SAMPLE_W-1:0] smp, input bit fe);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= smp;
    frame_end <= fe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  task automatic push_item(input logic signed [SAMPLE_W-1:0] smp, input bit fe,
                           input bit typed, input int exp_n,
                           input logic signed [SAMPLE_W-1:0] exp_smp);
    mono_out_t o;
    int        n;
    send_pcm(smp, fe);
    n = downmix_interp_step(smp, fe);
    if (typed) begin
      if (exp_n != 0) begin
        o.smp = exp_smp;
        o.last = 1'b1;
        expected_mono.insert(expected_mono.size(), o);
      end
    end else begin
      for (int i = 0; i < n; i++) expected_mono.insert(expected_mono.size(), run_buf[i]);
    end
  endtask

  // called in the step of the last transfer, so in_valid gets one update here
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_mono.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CC_W-1:0] cc, input bit on,
                          input logic [STEP_W-1:0] stp);
    cfg_write <= 1'b1;
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data <= {16'($urandom), cc};
    @(posedge clk);
    cfg_index <= REG_RESAMPLE_ON;
    cfg_data <= {19'($urandom), on};
    @(posedge clk);
    cfg_index <= REG_PHASE_STEP;
    cfg_data <= stp;
    @(posedge clk);
    cfg_write <= 1'b0;
    cc_reg = cc;
    on_reg = on;
    step_reg = stp;
    n_settings++;
  endtask

  // mostly well-formed frames, some cut short by frame_end, some noise
  task automatic random_frames(input int n_want);
    int                         sent;
    int                         eff;
    int                         len;
    int                         shape;
    int                         mode;
    bit                         fe;
    logic signed [SAMPLE_W-1:0] base;
    logic signed [SAMPLE_W-1:0] smp;
    sent = 0;
    while (sent < n_want) begin
      eff = eff_count(cc_reg);
      shape = $urandom_range(0, 9);
      mode = $urandom_range(0, 3);
      base = SAMPLE_W'($urandom);
      len = (shape == 0) ? $urandom_range(1, eff) : eff;
      for (int k = 0; k < len; k++) begin
        case (shape)
          // random early closes, but the burst always ends on a closed frame
          1:       fe = (k == len - 1) ? 1'b1 : 1'($urandom_range(0, 1));
          2:       fe = 1'b0;
          default: fe = (k == len - 1);
        endcase
        case (mode)
          0: smp = SAMPLE_W'($urandom);
          1: smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          default: begin
            base = base + SAMPLE_W'($urandom_range(0, 512)) - 16'sd256;
            smp = base;
          end
        endcase
        push_item(smp, fe, 1'b0, 0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    mono_out_t e;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_mono.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $error("sample_out: expected no transfer, got %0d", sample_out);
      end else begin
        e = expected_mono.pop_front();
        if (sample_out !== e.smp) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $error("sample_out: expected %0d, got %0d", e.smp, sample_out);
        end
        if (run_last !== e.last) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $error("run_last: expected %0b, got %0b", e.last, run_last);
        end
      end
    end
  end

  initial begin
    logic [CC_W-1:0]   cc;
    bit                on;
    logic [STEP_W-1:0] stp;
    rst <= 1'b1;
    in_valid <= 1'b0;
    sample_in <= '0;
    frame_end <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // first mono sample after reset is only stored
    tab_cfg(4'd1, 1'b1, STEP_RESET);
    tab_item(16'sd1000, 1'b0, 1'b1, 0, '0);
    tab_item(16'sd2000, 1'b0, 1'b1, 1, 16'sd1000);
    tab_item(16'sd3000, 1'b1, 1'b1, 1, 16'sd2000);
    tab_cfg(4'd1, 1'b0, STEP_RESET);
    tab_item(16'sh7FFF, 1'b0, 1'b1, 1, 16'sh7FFF);
    tab_item(16'sh8000, 1'b1, 1'b1, 1, 16'sh8000);
    tab_cfg(4'd2, 1'b0, STEP_RESET);
    tab_item(16'sh7FFF, 1'b0, 1'b1, 0, '0);
    tab_item(16'sh7FFF, 1'b0, 1'b1, 1, 16'sh7FFF);
    tab_item(16'sh8000, 1'b0, 1'b1, 0, '0);
    tab_item(-16'sd1, 1'b0, 1'b1, 1, -16'sd16384);
    // frame_end cuts the frame short, divisor stays two
    tab_item(16'sd100, 1'b1, 1'b1, 1, 16'sd50);
    tab_cfg(4'd0, 1'b0, STEP_RESET);
    tab_item(-16'sd5, 1'b0, 1'b1, 1, -16'sd5);
    // fifteen channels clamp to eight
    tab_cfg(4'd15, 1'b0, STEP_RESET);
    for (int i = 0; i < 7; i++) tab_item(16'sh8000, 1'b0, 1'b1, 0, '0);
    tab_item(16'sh8000, 1'b1, 1'b1, 1, 16'sh8000);
    // step below one eighth, full-scale swings
    tab_cfg(4'd1, 1'b1, '0);
    tab_item(16'sh8000, 1'b0, 1'b0, 0, '0);
    tab_item(16'sh7FFF, 1'b0, 1'b0, 0, '0);
    tab_item(16'sd0, 1'b1, 1'b0, 0, '0);
    tab_cfg(4'd1, 1'b1, STEP_TOP);
    tab_item(16'sh7FFF, 1'b0, 1'b0, 0, '0);
    tab_item(16'sh8000, 1'b0, 1'b0, 0, '0);
    tab_cfg(4'd1, 1'b1, 20'd786432);
    tab_item(16'sd5, 1'b0, 1'b0, 0, '0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        set_regs(dir_tab[i].cc, dir_tab[i].on, dir_tab[i].stp);
      end else begin
        push_item(dir_tab[i].smp, dir_tab[i].fe, dir_tab[i].typed,
                  dir_tab[i].exp_n, dir_tab[i].exp_smp);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      if (ph == RAND_PHASES - 1) quiet = 1'b1;
      cc = ($urandom_range(0, 3) == 0) ? CC_W'($urandom_range(0, 15))
                                       : CC_W'($urandom_range(1, 8));
      on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       stp = '0;
        1:       stp = STEP_W'($urandom_range(1, 8191));
        2:       stp = 20'd8192;
        3:       stp = 20'd786432;
        4:       stp = STEP_TOP;
        default: stp = STEP_W'($urandom_range(8192, 786432));
      endcase
      set_regs(cc, on, stp);
      random_frames(PHASE_ITEMS);
    end
    settle();

    $display("run covered %0d pcm transfers under %0d register settings,", n_items,
             n_settings);
    $display("%0d mono results scored, %0d mismatches", n_results, n_fail);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
